// ===== design/bsc_pkg.sv =====
// Shared types, constants and the microcode table of the barometric compensation block.
package bsc_pkg;

    // Default number of extra fraction bits that are carried through the divisions.
    localparam int unsigned EXTRA_FRAC_BITS_DEF = 5;

    // Field widths.
    localparam int unsigned RAW_W   = 24;
    localparam int unsigned COEF_W  = 16;
    localparam int unsigned PRES_W  = 22;
    localparam int unsigned TEMP_W  = 19;
    localparam int unsigned CFG_IDX_W = 3;

    // Internal datapath widths.
    localparam int unsigned DT_W      = 26;
    localparam int unsigned MUL_A_W   = 27;
    localparam int unsigned MUL_B_W   = 25;
    localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
    localparam int unsigned SENS_W    = 34;
    localparam int unsigned SENS_LO_W = 19;
    localparam int unsigned SENS_HI_W = SENS_W - SENS_LO_W;
    localparam int unsigned OFF_W     = 36;
    localparam int unsigned ACC_W     = 60;
    localparam int unsigned DIFF_W    = 40;

    // Fixed shifts of the compensation formulas.
    localparam int unsigned TREF_SH     = 8;
    localparam int unsigned SENS_BASE_SH = 15;
    localparam int unsigned SENS_TC_SH  = 8;
    localparam int unsigned OFF_BASE_SH = 16;
    localparam int unsigned OFF_TC_SH   = 7;
    localparam int unsigned PRES_SH     = 21;
    localparam int unsigned TEMP_BASE   = 2000;

    // Calibration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SENS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TREF      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TSENS     = 3'd5;

    // Item kinds.
    localparam logic REQ_TEMP = 1'b0;
    localparam logic REQ_PRES = 1'b1;

    // Microprogram geometry.
    localparam int unsigned STEP_W = 4;
    localparam logic [STEP_W-1:0] TEMP_ENTRY = 4'd0;
    localparam logic [STEP_W-1:0] PRES_ENTRY = 4'd4;
    localparam logic [STEP_W-1:0] PRES_EXIT  = 4'd11;

    // Sequencer state.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Register load performed by one step.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LD_DT,
        OP_LD_TEMP,
        OP_LD_SENS,
        OP_LD_OFF,
        OP_LD_ACC,
        OP_ADD_ACC,
        OP_LD_DIFF,
        OP_LD_PRES
    } t_alu_op;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DT_TSENS,
        MUL_DT_SENS_TC,
        MUL_DT_OFF_TC,
        MUL_SENS_LO,
        MUL_SENS_HI
    } t_mul_sel;

    // Step sequencing.
    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_BR_NRDY,
        SQ_END
    } t_seq_op;

    typedef struct packed {
        t_alu_op           alu;
        t_mul_sel          mul;
        t_seq_op           seq;
        logic [STEP_W-1:0] target;
    } t_ucode;

    // Microcode ROM: temperature program at step 0, pressure program at step 4.
    function automatic t_ucode ucode_rom(input logic [STEP_W-1:0] step);
        t_ucode w;
        w = '{alu: OP_NOP, mul: MUL_NONE, seq: SQ_END, target: '0};
        case (step)
            4'd0:  w = '{alu: OP_LD_DT,   mul: MUL_NONE,       seq: SQ_NEXT, target: '0};
            4'd1:  w = '{alu: OP_NOP,     mul: MUL_DT_TSENS,   seq: SQ_NEXT, target: '0};
            4'd2:  w = '{alu: OP_LD_TEMP, mul: MUL_NONE,       seq: SQ_NEXT, target: '0};
            4'd3:  w = '{alu: OP_NOP,     mul: MUL_NONE,       seq: SQ_END,  target: '0};
            4'd4:  w = '{alu: OP_NOP,     mul: MUL_DT_SENS_TC, seq: SQ_BR_NRDY,
                        target: PRES_EXIT};
            4'd5:  w = '{alu: OP_LD_SENS, mul: MUL_DT_OFF_TC,  seq: SQ_NEXT, target: '0};
            4'd6:  w = '{alu: OP_LD_OFF,  mul: MUL_SENS_LO,    seq: SQ_NEXT, target: '0};
            4'd7:  w = '{alu: OP_LD_ACC,  mul: MUL_SENS_HI,    seq: SQ_NEXT, target: '0};
            4'd8:  w = '{alu: OP_ADD_ACC, mul: MUL_NONE,       seq: SQ_NEXT, target: '0};
            4'd9:  w = '{alu: OP_LD_DIFF, mul: MUL_NONE,       seq: SQ_NEXT, target: '0};
            4'd10: w = '{alu: OP_LD_PRES, mul: MUL_NONE,       seq: SQ_NEXT, target: '0};
            4'd11: w = '{alu: OP_NOP,     mul: MUL_NONE,       seq: SQ_END,  target: '0};
            default: w = '{alu: OP_NOP,   mul: MUL_NONE,       seq: SQ_END,  target: '0};
        endcase
        return w;
    endfunction

endpackage

// ===== design/baro_sensor_compensation.sv =====
// Top level of the barometric sensor first-order compensation block.
//
//  Channel   Signals                                       Direction
//  -------   --------------------------------------------  ---------
//  input     i_in_valid / o_in_ready, i_req_type,          in
//            i_raw_reading
//  result    o_out_valid / i_out_ready, o_pressure_pa,     out
//            o_temp_centideg, o_updated
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_wdata         in
//
// A temperature item runs the temperature program and a pressure item the pressure program;
// a pressure item without a pending temperature branches from its first step to its last.
// Both programs share the one 27 x 25 multiplier.
// The next item is accepted while the previous result still waits in the output register.
// If the output register is still full and not being taken at the last step, the sequencer holds there.
// Reset is synchronous and clears the coefficients, the held values and all control state.
module baro_sensor_compensation #(
    parameter int unsigned EXTRA_FRAC_BITS = bsc_pkg::EXTRA_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [bsc_pkg::RAW_W-1:0]           i_raw_reading,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bsc_pkg::PRES_W-1:0]   o_pressure_pa,
    output logic signed [bsc_pkg::TEMP_W-1:0]   o_temp_centideg,
    output logic                                o_updated,
    input  logic                                i_cfg_wr_en,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bsc_pkg::COEF_W-1:0]          i_cfg_wdata
);
    import bsc_pkg::*;

    localparam int unsigned TEMP_SH = 23 - EXTRA_FRAC_BITS;
    localparam int unsigned DIFF_SH = 15 - EXTRA_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] TEMP_BIAS =
        PROD_W'(TEMP_BASE) << EXTRA_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] RND_PROD =
        (PROD_W'(1) << EXTRA_FRAC_BITS) - PROD_W'(1);
    localparam logic signed [DIFF_W-1:0] RND_DIFF =
        (DIFF_W'(1) << EXTRA_FRAC_BITS) - DIFF_W'(1);

    // Calibration coefficients.
    logic [COEF_W-1:0] r_c_sens, r_c_offset, r_c_sens_tc, r_c_offset_tc, r_c_tref, r_c_tsens;

    // Sequencer control.
    t_seq_state        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_ucode            uc;
    logic              accept;
    logic              advance;
    logic              seq_done;

    // Architectural state.
    logic signed [DT_W-1:0]   r_temp_delta, n_temp_delta;
    logic signed [TEMP_W-1:0] r_pending_temp, n_pending_temp;
    logic                     r_temp_ready, n_temp_ready;
    logic signed [PRES_W-1:0] r_held_pressure, n_held_pressure;
    logic signed [TEMP_W-1:0] r_held_temp, n_held_temp;
    logic                     r_done, n_done;

    // Working registers.
    logic [RAW_W-1:0]          r_raw;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [SENS_W-1:0]  r_sens, n_sens;
    logic signed [OFF_W-1:0]   r_off, n_off;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [DIFF_W-1:0]  r_diff, n_diff;

    // Output register.
    logic                     r_out_valid, n_out_valid;
    logic signed [PRES_W-1:0] r_out_pressure;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic                     r_out_updated;

    // Datapath intermediates.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  prod_sh_temp, temp_sum, temp_adj, temp_q;
    logic signed [PROD_W-1:0]  prod_sh_sens, prod_sh_off;
    logic signed [ACC_W-1:0]   acc_hi, acc_sh;
    logic signed [DIFF_W-1:0]  diff_sh, diff_adj, diff_q;

    assign uc     = ucode_rom(r_step);
    assign accept = i_in_valid && o_in_ready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (accept) begin
                    n_state = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (seq_done) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, step advance and program end.
    always_comb begin
        o_in_ready = 1'b0;
        advance    = 1'b0;
        seq_done   = 1'b0;
        case (r_state)
            SEQ_IDLE: o_in_ready = 1'b1;
            SEQ_RUN: begin
                if (uc.seq == SQ_END) begin
                    advance  = !r_out_valid || i_out_ready;
                    seq_done = advance;
                end else begin
                    advance = 1'b1;
                end
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // Step counter with conditional branch.
    always_comb begin
        n_step = r_step;
        if (accept) begin
            n_step = (i_req_type == REQ_PRES) ? PRES_ENTRY : TEMP_ENTRY;
        end else if (advance) begin
            case (uc.seq)
                SQ_NEXT:    n_step = r_step + STEP_W'(1);
                SQ_BR_NRDY: n_step = r_temp_ready ? r_step + STEP_W'(1) : uc.target;
                SQ_END:     n_step = r_step;
                default:    n_step = r_step;
            endcase
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (uc.mul)
            MUL_DT_TSENS: begin
                mul_a = MUL_A_W'(r_temp_delta);
                mul_b = $signed(MUL_B_W'(r_c_tsens));
            end
            MUL_DT_SENS_TC: begin
                mul_a = MUL_A_W'(r_temp_delta);
                mul_b = $signed(MUL_B_W'(r_c_sens_tc));
            end
            MUL_DT_OFF_TC: begin
                mul_a = MUL_A_W'(r_temp_delta);
                mul_b = $signed(MUL_B_W'(r_c_offset_tc));
            end
            MUL_SENS_LO: begin
                mul_a = $signed(MUL_A_W'(r_sens[SENS_LO_W-1:0]));
                mul_b = $signed(MUL_B_W'(r_raw));
            end
            MUL_SENS_HI: begin
                mul_a = MUL_A_W'($signed(r_sens[SENS_W-1:SENS_LO_W]));
                mul_b = $signed(MUL_B_W'(r_raw));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Temperature: floor shift of dT * C6, add the base, truncate toward zero.
    assign prod_sh_temp = r_prod >>> TEMP_SH;
    assign temp_sum     = TEMP_BIAS + prod_sh_temp;
    assign temp_adj     = temp_sum + (temp_sum[PROD_W-1] ? RND_PROD : '0);
    assign temp_q       = temp_adj >>> EXTRA_FRAC_BITS;

    // Sensitivity and offset correction terms.
    assign prod_sh_sens = r_prod >>> SENS_TC_SH;
    assign prod_sh_off  = r_prod >>> OFF_TC_SH;

    // Raw times sensitivity is assembled from two partial products.
    assign acc_hi = ACC_W'(r_prod) <<< SENS_LO_W;
    assign acc_sh = r_acc >>> PRES_SH;

    // Pressure: floor shift of the difference, then truncate toward zero.
    assign diff_sh  = r_diff >>> DIFF_SH;
    assign diff_adj = diff_sh + (diff_sh[DIFF_W-1] ? RND_DIFF : '0);
    assign diff_q   = diff_adj >>> EXTRA_FRAC_BITS;

    // Register loads selected by the control word.
    always_comb begin
        n_temp_delta    = r_temp_delta;
        n_pending_temp  = r_pending_temp;
        n_temp_ready    = r_temp_ready;
        n_held_pressure = r_held_pressure;
        n_held_temp     = r_held_temp;
        n_done          = r_done;
        n_prod          = r_prod;
        n_sens          = r_sens;
        n_off           = r_off;
        n_acc           = r_acc;
        n_diff          = r_diff;
        if (accept) begin
            n_done = 1'b0;
        end else if (advance) begin
            if (uc.mul != MUL_NONE) begin
                n_prod = mul_p;
            end
            case (uc.alu)
                OP_LD_DT: begin
                    n_temp_delta = $signed({2'b00, r_raw})
                                 - $signed({2'b00, r_c_tref, TREF_SH'(0)});
                end
                OP_LD_TEMP: begin
                    n_pending_temp = temp_q[TEMP_W-1:0];
                    n_temp_ready   = 1'b1;
                end
                OP_LD_SENS: begin
                    n_sens = $signed({3'b000, r_c_sens, SENS_BASE_SH'(0)})
                           + $signed(prod_sh_sens[SENS_W-1:0]);
                end
                OP_LD_OFF: begin
                    n_off = $signed({4'b0000, r_c_offset, OFF_BASE_SH'(0)})
                          + $signed(prod_sh_off[OFF_W-1:0]);
                end
                OP_LD_ACC:  n_acc = ACC_W'(r_prod);
                OP_ADD_ACC: n_acc = r_acc + acc_hi;
                OP_LD_DIFF: begin
                    n_diff = $signed(acc_sh[DIFF_W-1:0]) - DIFF_W'(r_off);
                end
                OP_LD_PRES: begin
                    n_held_pressure = diff_q[PRES_W-1:0];
                    n_held_temp     = r_pending_temp;
                    n_temp_ready    = 1'b0;
                    n_done          = 1'b1;
                end
                default: n_done = r_done;
            endcase
        end
    end

    // Output register valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (seq_done) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and architectural state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= SEQ_IDLE;
            r_step          <= '0;
            r_out_valid     <= 1'b0;
            r_temp_delta    <= '0;
            r_pending_temp  <= '0;
            r_temp_ready    <= 1'b0;
            r_held_pressure <= '0;
            r_held_temp     <= '0;
            r_done          <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_step          <= n_step;
            r_out_valid     <= n_out_valid;
            r_temp_delta    <= n_temp_delta;
            r_pending_temp  <= n_pending_temp;
            r_temp_ready    <= n_temp_ready;
            r_held_pressure <= n_held_pressure;
            r_held_temp     <= n_held_temp;
            r_done          <= n_done;
        end
    end

    // Calibration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_sens      <= '0;
            r_c_offset    <= '0;
            r_c_sens_tc   <= '0;
            r_c_offset_tc <= '0;
            r_c_tref      <= '0;
            r_c_tsens     <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SENS:      r_c_sens      <= i_cfg_wdata;
                REG_OFFSET:    r_c_offset    <= i_cfg_wdata;
                REG_SENS_TC:   r_c_sens_tc   <= i_cfg_wdata;
                REG_OFFSET_TC: r_c_offset_tc <= i_cfg_wdata;
                REG_TREF:      r_c_tref      <= i_cfg_wdata;
                REG_TSENS:     r_c_tsens     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw <= i_raw_reading;
        end
        r_prod <= n_prod;
        r_sens <= n_sens;
        r_off  <= n_off;
        r_acc  <= n_acc;
        r_diff <= n_diff;
        if (seq_done) begin
            r_out_pressure <= r_held_pressure;
            r_out_temp     <= r_held_temp;
            r_out_updated  <= r_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pressure_pa   = r_out_pressure;
    assign o_temp_centideg = r_out_temp;
    assign o_updated       = r_out_updated;

endmodule

// ===== design/bsc_checker.sv =====
// Port-level checker for the barometric compensation block and its bind statement.
module bsc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [bsc_pkg::PRES_W-1:0]   o_pressure_pa,
    input logic signed [bsc_pkg::TEMP_W-1:0]   o_temp_centideg,
    input logic                                o_updated
);
    import bsc_pkg::*;

    // Every program runs at least two steps, so the input stays closed meanwhile.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("input reopened too soon after an accepted item");

    // A waiting result is neither dropped nor altered.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pressure_pa)
            && $stable(o_temp_centideg) && $stable(o_updated))
        else $error("waiting result changed before it was taken");

    // Reset leaves the block empty and ready for an item.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    // A result only appears after the sequencer has been busy with an item.
    a_result_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without an item in flight");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_pressure_pa   (o_pressure_pa),
    .o_temp_centideg (o_temp_centideg),
    .o_updated       (o_updated)
);
